>>> design/lzma_range_decoder_macros.svh
// Assertion macros for the LZMA range decoder.
// Used by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef LZMA_RANGE_DECODER_MACROS_SVH
`define LZMA_RANGE_DECODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LZRD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LZRD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/lzrd_pkg.sv
// Shared types and constants of the LZMA range decoder.
// No dependencies; used by lzrd_alu and lzma_range_decoder.
`timescale 1ns / 1ps

package lzrd_pkg;

  localparam int PROB_DEPTH_DEF    = 4096;
  localparam int QUEUE_DEPTH_DEF   = 16;
  localparam int MAX_TREE_BITS_DEF = 8;

  localparam logic [31:0] TOP_VALUE       = 32'h0100_0000;
  localparam logic [11:0] PROB_ONE        = 12'h800;
  localparam int          PROB_BITS       = 11;
  localparam int          MOVE_BITS       = 5;
  localparam int          START_BYTES     = 5;
  localparam int          MAX_DIRECT_BITS = 32;

  typedef enum logic [2:0] {
    ACT_PUSH   = 3'd0,
    ACT_START  = 3'd1,
    ACT_ADAPT  = 3'd2,
    ACT_DIRECT = 3'd3,
    ACT_TREE   = 3'd4,
    ACT_WPROB  = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    STS_OK     = 2'd0,
    STS_NODATA = 2'd1,
    STS_BAD    = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PUSH,
    ST_WRITE,
    ST_LOAD,
    ST_DBIT,
    ST_PREAD,
    ST_MUL,
    ST_ABIT,
    ST_DONE
  } state_e;

  typedef enum logic {
    ALU_ADAPT,
    ALU_DIRECT
  } alu_op_e;

  typedef struct packed {
    logic [31:0] rng;
    logic [31:0] code;
    logic        dbit;
    logic        hit;
    logic        pop;
    logic        starve;
  } alu_res_t;

endpackage

>>> design/lzrd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the byte queue and the probability store.
`timescale 1ns / 1ps

module lzrd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/lzrd_alu.sv
// Shared bit-decode unit: one adaptive or direct bit step followed by one
// normalization step. Depends on lzrd_pkg.
`timescale 1ns / 1ps

module lzrd_alu (
  input  lzrd_pkg::alu_op_e  op_i,
  input  logic [31:0]        rng_i,
  input  logic [31:0]        code_i,
  input  logic [31:0]        bound_i,
  input  logic [7:0]         byte_i,
  input  logic               avail_i,
  output lzrd_pkg::alu_res_t res_o
);

  logic [31:0] rng_half;
  logic [31:0] sub_b;
  logic [32:0] diff;
  logic [31:0] rng_s;
  logic [31:0] code_s;
  logic        dbit;
  logic        hit;
  logic        need;

  always_comb begin
    rng_half = {1'b0, rng_i[31:1]};
    sub_b    = (op_i == lzrd_pkg::ALU_DIRECT) ? rng_half : bound_i;
    diff     = {1'b0, code_i} - {1'b0, sub_b};
    if (op_i == lzrd_pkg::ALU_DIRECT) begin
      rng_s  = rng_half;
      code_s = diff[31] ? code_i : diff[31:0];
      dbit   = ~diff[31];
      hit    = (code_s == rng_half);
    end else if (diff[32]) begin
      rng_s  = bound_i;
      code_s = code_i;
      dbit   = 1'b0;
      hit    = 1'b0;
    end else begin
      rng_s  = rng_i - bound_i;
      code_s = diff[31:0];
      dbit   = 1'b1;
      hit    = 1'b0;
    end
    need = (rng_s < lzrd_pkg::TOP_VALUE);
  end

  always_comb begin
    res_o.dbit   = dbit;
    res_o.hit    = hit;
    res_o.pop    = need & avail_i;
    res_o.starve = need & ~avail_i;
    if (need & avail_i) begin
      res_o.rng  = {rng_s[23:0], 8'h00};
      res_o.code = {code_s[23:0], byte_i};
    end else begin
      res_o.rng  = rng_s;
      res_o.code = code_s;
    end
  end

endmodule

>>> design/lzma_range_decoder.sv
// LZMA range decoder; takes a new request only once busy is low. Push and probability
// write: ST_PUSH or ST_WRITE, then the strobe. Start: the five header bytes load in ST_LOAD.
// Direct bits: one bit per cycle. Adaptive bit or reverse tree: a store read, multiply and
// step per bit. Rejected requests: strobe in the cycle after start; it cannot be stalled.
// Reset is asynchronous and active low; afterwards the decoder is halted until a start.
`timescale 1ns / 1ps
`include "lzma_range_decoder_macros.svh"

module lzma_range_decoder #(
  parameter int PROB_DEPTH    = lzrd_pkg::PROB_DEPTH_DEF,
  parameter int QUEUE_DEPTH   = lzrd_pkg::QUEUE_DEPTH_DEF,
  parameter int MAX_TREE_BITS = lzrd_pkg::MAX_TREE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  action_i,
  input  logic [7:0]  data_byte_i,
  input  logic [11:0] prob_index_i,
  input  logic [5:0]  bit_count_i,
  input  logic [10:0] prob_value_i,
  output logic        valid_o,
  output logic [31:0] value_o,
  output logic [1:0]  status_o,
  output logic        corrupted_o
);

  localparam int AW  = $clog2(PROB_DEPTH);
  localparam int QAW = $clog2(QUEUE_DEPTH);
  localparam int LW  = $clog2(QUEUE_DEPTH + 1);
  localparam int TW  = LW + 1;
  localparam int NW  = MAX_TREE_BITS + 1;
  localparam int CW  = 18;

  lzrd_pkg::state_e  state_q, state_d;
  lzrd_pkg::status_e sts_q, sts_d, req_sts;

  logic [31:0]   rng_q, rng_d;
  logic [31:0]   code_q, code_d;
  logic          corrupt_q, corrupt_d;
  logic          halted_q, halted_d;
  logic [QAW-1:0] head_q, head_d;
  logic [LW-1:0] level_q, level_d;

  logic [31:0]   val_q, val_d;
  logic          tree_q, tree_d;
  logic [7:0]    data_q, data_d;
  logic [11:0]   base_q, base_d;
  logic [5:0]    cnt_q, cnt_d;
  logic [4:0]    pos_q, pos_d;
  logic [NW-1:0] node_q, node_d;
  logic [AW-1:0] addr_q, addr_d;
  logic [10:0]   pval_q, pval_d;
  logic [10:0]   p_q, p_d;
  logic [31:0]   bound_q, bound_d;

  logic          accept;
  logic          req_go;
  logic          bad_idx;
  logic          bad_tree;
  logic          q_full;
  logic          q_short;
  logic [CW-1:0] tree_top;
  logic [TW-1:0] tail_sum;
  logic [QAW-1:0] q_tail;
  logic [QAW-1:0] head_inc;
  logic          q_we;
  logic          q_pop;
  logic [7:0]    q_rdata;
  logic          p_we;
  logic [10:0]   p_wdata;
  logic [10:0]   p_rdata;
  logic [10:0]   p_up;
  logic [10:0]   p_down;
  logic [10:0]   p_new;
  logic [NW-1:0] node_nx;

  lzrd_pkg::alu_op_e  alu_op;
  lzrd_pkg::alu_res_t alu_res;

  lzrd_ram #(
    .WIDTH (8),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_tail),
    .wdata_i (data_q),
    .raddr_i (head_d),
    .rdata_o (q_rdata)
  );

  lzrd_ram #(
    .WIDTH (lzrd_pkg::PROB_BITS),
    .DEPTH (PROB_DEPTH)
  ) u_prob (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (addr_q),
    .wdata_i (p_wdata),
    .raddr_i (addr_q),
    .rdata_o (p_rdata)
  );

  lzrd_alu u_alu (
    .op_i    (alu_op),
    .rng_i   (rng_q),
    .code_i  (code_q),
    .bound_i (bound_q),
    .byte_i  (q_rdata),
    .avail_i (level_q != '0),
    .res_o   (alu_res)
  );

  assign accept   = start & ~busy;
  assign q_full   = (level_q >= LW'(QUEUE_DEPTH));
  assign q_short  = (level_q < LW'(lzrd_pkg::START_BYTES));
  assign bad_idx  = (CW'(prob_index_i) >= CW'(PROB_DEPTH));
  assign tree_top = CW'(prob_index_i) + (CW'(1) << bit_count_i) - CW'(1);
  assign bad_tree = (bit_count_i > 6'(MAX_TREE_BITS)) ||
                    ((bit_count_i != '0) && (tree_top >= CW'(PROB_DEPTH)));

  assign tail_sum = TW'(head_q) + TW'(level_q);
  assign q_tail   = (tail_sum >= TW'(QUEUE_DEPTH)) ? QAW'(tail_sum - TW'(QUEUE_DEPTH))
                                                   : QAW'(tail_sum);
  assign head_inc = (head_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : head_q + QAW'(1);

  assign p_up    = p_q + 11'((lzrd_pkg::PROB_ONE - {1'b0, p_q}) >> lzrd_pkg::MOVE_BITS);
  assign p_down  = p_q - (p_q >> lzrd_pkg::MOVE_BITS);
  assign p_new   = alu_res.dbit ? p_down : p_up;
  assign node_nx = {node_q[NW-2:0], alu_res.dbit};

  always_comb begin
    req_sts = lzrd_pkg::STS_OK;
    req_go  = 1'b1;
    case (action_i)
      lzrd_pkg::ACT_PUSH: begin
        if (q_full) begin
          req_sts = lzrd_pkg::STS_BAD;
          req_go  = 1'b0;
        end
      end
      lzrd_pkg::ACT_START: begin
        if (q_short) begin
          req_sts = lzrd_pkg::STS_NODATA;
          req_go  = 1'b0;
        end
      end
      lzrd_pkg::ACT_ADAPT: begin
        if (bad_idx) begin
          req_sts = lzrd_pkg::STS_BAD;
          req_go  = 1'b0;
        end else if (halted_q) begin
          req_sts = lzrd_pkg::STS_NODATA;
          req_go  = 1'b0;
        end
      end
      lzrd_pkg::ACT_DIRECT: begin
        if (bit_count_i > 6'(lzrd_pkg::MAX_DIRECT_BITS)) begin
          req_sts = lzrd_pkg::STS_BAD;
          req_go  = 1'b0;
        end else if (halted_q) begin
          req_sts = lzrd_pkg::STS_NODATA;
          req_go  = 1'b0;
        end else if (bit_count_i == '0) begin
          req_go = 1'b0;
        end
      end
      lzrd_pkg::ACT_TREE: begin
        if (bad_tree) begin
          req_sts = lzrd_pkg::STS_BAD;
          req_go  = 1'b0;
        end else if (halted_q) begin
          req_sts = lzrd_pkg::STS_NODATA;
          req_go  = 1'b0;
        end else if (bit_count_i == '0) begin
          req_go = 1'b0;
        end
      end
      lzrd_pkg::ACT_WPROB: begin
        if (bad_idx) begin
          req_sts = lzrd_pkg::STS_BAD;
          req_go  = 1'b0;
        end
      end
      default: begin
        req_sts = lzrd_pkg::STS_BAD;
        req_go  = 1'b0;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      lzrd_pkg::ST_IDLE: begin
        if (accept) begin
          if (!req_go) begin
            state_d = lzrd_pkg::ST_DONE;
          end else begin
            case (action_i)
              lzrd_pkg::ACT_PUSH:   state_d = lzrd_pkg::ST_PUSH;
              lzrd_pkg::ACT_START:  state_d = lzrd_pkg::ST_LOAD;
              lzrd_pkg::ACT_ADAPT:  state_d = lzrd_pkg::ST_PREAD;
              lzrd_pkg::ACT_DIRECT: state_d = lzrd_pkg::ST_DBIT;
              lzrd_pkg::ACT_TREE:   state_d = lzrd_pkg::ST_PREAD;
              lzrd_pkg::ACT_WPROB:  state_d = lzrd_pkg::ST_WRITE;
              default:              state_d = lzrd_pkg::ST_DONE;
            endcase
          end
        end
      end
      lzrd_pkg::ST_PUSH:  state_d = lzrd_pkg::ST_DONE;
      lzrd_pkg::ST_WRITE: state_d = lzrd_pkg::ST_DONE;
      lzrd_pkg::ST_LOAD: begin
        if (cnt_q == 6'(lzrd_pkg::START_BYTES - 1)) begin
          state_d = lzrd_pkg::ST_DONE;
        end
      end
      lzrd_pkg::ST_DBIT: begin
        if (alu_res.starve || (cnt_q == 6'd1)) begin
          state_d = lzrd_pkg::ST_DONE;
        end
      end
      lzrd_pkg::ST_PREAD: state_d = lzrd_pkg::ST_MUL;
      lzrd_pkg::ST_MUL:   state_d = lzrd_pkg::ST_ABIT;
      lzrd_pkg::ST_ABIT: begin
        if (alu_res.starve || !tree_q || (cnt_q == 6'd1)) begin
          state_d = lzrd_pkg::ST_DONE;
        end else begin
          state_d = lzrd_pkg::ST_PREAD;
        end
      end
      lzrd_pkg::ST_DONE: state_d = lzrd_pkg::ST_IDLE;
      default:           state_d = lzrd_pkg::ST_IDLE;
    endcase
  end

  // State machine outputs.
  always_comb begin
    busy    = (state_q != lzrd_pkg::ST_IDLE);
    valid_o = (state_q == lzrd_pkg::ST_DONE);
    q_we    = (state_q == lzrd_pkg::ST_PUSH);
    q_pop   = (state_q == lzrd_pkg::ST_LOAD) ||
              (((state_q == lzrd_pkg::ST_DBIT) || (state_q == lzrd_pkg::ST_ABIT)) &&
               alu_res.pop);
    p_we    = (state_q == lzrd_pkg::ST_WRITE) || (state_q == lzrd_pkg::ST_ABIT);
    p_wdata = (state_q == lzrd_pkg::ST_WRITE) ? pval_q : p_new;
    alu_op  = (state_q == lzrd_pkg::ST_DBIT) ? lzrd_pkg::ALU_DIRECT : lzrd_pkg::ALU_ADAPT;
  end

  // Datapath next values.
  always_comb begin
    rng_d     = rng_q;
    code_d    = code_q;
    corrupt_d = corrupt_q;
    halted_d  = halted_q;
    head_d    = q_pop ? head_inc : head_q;
    level_d   = level_q;
    val_d     = val_q;
    sts_d     = sts_q;
    tree_d    = tree_q;
    data_d    = data_q;
    base_d    = base_q;
    cnt_d     = cnt_q;
    pos_d     = pos_q;
    node_d    = node_q;
    addr_d    = addr_q;
    pval_d    = pval_q;
    p_d       = p_q;
    bound_d   = bound_q;
    if (q_pop) begin
      level_d = level_q - LW'(1);
    end
    case (state_q)
      lzrd_pkg::ST_IDLE: begin
        if (accept) begin
          sts_d  = req_sts;
          val_d  = '0;
          tree_d = (action_i == lzrd_pkg::ACT_TREE);
          data_d = data_byte_i;
          base_d = prob_index_i;
          pval_d = prob_value_i;
          cnt_d  = (action_i == lzrd_pkg::ACT_START) ? '0 : bit_count_i;
          pos_d  = '0;
          node_d = NW'(1);
          addr_d = AW'(CW'(prob_index_i) + CW'(action_i == lzrd_pkg::ACT_TREE));
          if ((action_i == lzrd_pkg::ACT_START) && q_short) begin
            halted_d = 1'b1;
          end
        end
      end
      lzrd_pkg::ST_PUSH: begin
        level_d = level_q + LW'(1);
      end
      lzrd_pkg::ST_LOAD: begin
        if (cnt_q == '0) begin
          corrupt_d = (q_rdata != 8'h00);
        end else begin
          code_d = {code_q[23:0], q_rdata};
        end
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(lzrd_pkg::START_BYTES - 1)) begin
          rng_d    = '1;
          halted_d = 1'b0;
        end
      end
      lzrd_pkg::ST_DBIT: begin
        rng_d  = alu_res.rng;
        code_d = alu_res.code;
        if (alu_res.hit) begin
          corrupt_d = 1'b1;
        end
        if (alu_res.starve) begin
          sts_d    = lzrd_pkg::STS_NODATA;
          val_d    = '0;
          halted_d = 1'b1;
        end else begin
          val_d = {val_q[30:0], alu_res.dbit};
          cnt_d = cnt_q - 6'd1;
        end
      end
      lzrd_pkg::ST_MUL: begin
        p_d     = p_rdata;
        bound_d = 32'(rng_q[31:lzrd_pkg::PROB_BITS]) * 32'(p_rdata);
      end
      lzrd_pkg::ST_ABIT: begin
        rng_d  = alu_res.rng;
        code_d = alu_res.code;
        if (alu_res.starve) begin
          sts_d    = lzrd_pkg::STS_NODATA;
          val_d    = '0;
          halted_d = 1'b1;
        end else if (tree_q) begin
          val_d[pos_q] = alu_res.dbit;
          pos_d        = pos_q + 5'd1;
          cnt_d        = cnt_q - 6'd1;
          node_d       = node_nx;
          addr_d       = AW'(CW'(base_q) + CW'(node_nx));
        end else begin
          val_d = 32'(alu_res.dbit);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= lzrd_pkg::ST_IDLE;
      rng_q     <= '1;
      code_q    <= '0;
      corrupt_q <= 1'b0;
      halted_q  <= 1'b1;
      head_q    <= '0;
      level_q   <= '0;
    end else begin
      state_q   <= state_d;
      rng_q     <= rng_d;
      code_q    <= code_d;
      corrupt_q <= corrupt_d;
      halted_q  <= halted_d;
      head_q    <= head_d;
      level_q   <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q   <= val_d;
    sts_q   <= sts_d;
    tree_q  <= tree_d;
    data_q  <= data_d;
    base_q  <= base_d;
    cnt_q   <= cnt_d;
    pos_q   <= pos_d;
    node_q  <= node_d;
    addr_q  <= addr_d;
    pval_q  <= pval_d;
    p_q     <= p_d;
    bound_q <= bound_d;
  end

  assign value_o     = val_q;
  assign status_o    = sts_q;
  assign corrupted_o = corrupt_q;

  `LZRD_ASSERT_IMP(a_strobe_busy, clk_i, rst_ni, valid_o, busy,
                   "result word outside a request")
  `LZRD_ASSERT_IMP(a_level_max, clk_i, rst_ni, 1'b1, level_q <= LW'(QUEUE_DEPTH),
                   "queue overfilled")
  `LZRD_ASSERT_IMP(a_pop_nonempty, clk_i, rst_ni, q_pop, level_q != '0,
                   "pop from empty queue")
  `LZRD_ASSERT_IMP(a_decode_live, clk_i, rst_ni,
                   state_q == lzrd_pkg::ST_DBIT || state_q == lzrd_pkg::ST_ABIT, !halted_q,
                   "decode step while halted")
  `LZRD_ASSERT_NXT(a_done_once, clk_i, rst_ni, valid_o, !valid_o && !busy,
                   "result word repeated")

endmodule
